>>> rtl/core/gfpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gfpc_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_ADDR_W      = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int PIXEL_W         = 24;

   // Register map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_FRAME_LEFT        = 3'd0;
   localparam logic [2:0] REG_FRAME_TOP         = 3'd1;
   localparam logic [2:0] REG_FRAME_WIDTH       = 3'd2;
   localparam logic [2:0] REG_FRAME_HEIGHT      = 3'd3;
   localparam logic [2:0] REG_INTERLACED        = 3'd4;
   localparam logic [2:0] REG_TRANSPARENT_INDEX = 3'd5;
   localparam logic [2:0] REG_TRANSPARENCY_MODE = 3'd6;
   localparam logic [2:0] REG_BACKGROUND_RGB    = 3'd7;

   // Transparency modes; any other code skips the special index
   localparam logic [1:0] MODE_NONE       = 2'd0;
   localparam logic [1:0] MODE_BACKGROUND = 2'd1;

   // Input command codes
   localparam logic CMD_PALETTE = 1'b0;
   localparam logic CMD_PIXEL   = 1'b1;

   localparam logic [1:0] LAST_PASS = 2'd3;

   // First row of each interlace pass.
   function automatic logic [3:0] pass_start(input logic [1:0] pass);
      logic [3:0] row;
      case (pass)
         2'd0:    row = 4'd0;
         2'd1:    row = 4'd4;
         2'd2:    row = 4'd2;
         default: row = 4'd1;
      endcase
      return row;
   endfunction

   // Row step within each interlace pass.
   function automatic logic [3:0] pass_step(input logic [1:0] pass);
      logic [3:0] step;
      case (pass)
         2'd0:    step = 4'd8;
         2'd1:    step = 4'd8;
         2'd2:    step = 4'd4;
         default: step = 4'd2;
      endcase
      return step;
   endfunction

   // RGB (red in the top byte) to 0xFF, B, G, R.
   function automatic logic [31:0] pack_pixel(input logic [23:0] rgb);
      return {8'hff, rgb[7:0], rgb[15:8], rgb[23:16]};
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/gfpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gfpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                          wr_data,
   input  wire                                       rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/gif_frame_pixel_compositor_unit.sv
// Pipeline: an accepted transaction is registered in stage one and then in the response
// register, which drives the response port.
// Throughput: one transaction per cycle while the response side keeps up, palette writes
// and pixels alike; the palette RAM read is issued and the row/column counters step on accept.
// Reset (synchronous, active high) clears the counters, the pipeline valids and the
// configuration registers to their defaults; palette contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module gif_frame_pixel_compositor_unit (
   input  wire                                clock,
   input  wire                                reset,
   // Request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // tdata from bit 0: palette_slot[7:0], palette_rgb[31:8], pixel_index[39:32]
   input  wire  [39:0]                        req_tdata,
   // tuser: command (0 palette write, 1 pixel)
   input  wire                                req_tuser,
   // Response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // tdata from bit 0: dest_x[15:0], dest_y[31:16], pixel_value[63:32]
   output logic [63:0]                        rsp_tdata,
   // tuser: write_enable
   output logic                               rsp_tuser,
   // tlast: frame_done
   output logic                               rsp_tlast,
   // Register port
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [gfpc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0] frame_left_ff, frame_top_ff, frame_width_ff, frame_height_ff;
   logic        interlaced_ff;
   logic [7:0]  transparent_index_ff;
   logic [1:0]  transparency_mode_ff;
   logic [23:0] background_rgb_ff;

   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_left_ff        <= '0;
         frame_top_ff         <= '0;
         frame_width_ff       <= 16'd1;
         frame_height_ff      <= 16'd1;
         interlaced_ff        <= 1'b0;
         transparent_index_ff <= '0;
         transparency_mode_ff <= gfpc_pkg::MODE_NONE;
         background_rgb_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            gfpc_pkg::REG_FRAME_LEFT:        frame_left_ff        <= csr_pwdata[15:0];
            gfpc_pkg::REG_FRAME_TOP:         frame_top_ff         <= csr_pwdata[15:0];
            gfpc_pkg::REG_FRAME_WIDTH:       frame_width_ff       <= csr_pwdata[15:0];
            gfpc_pkg::REG_FRAME_HEIGHT:      frame_height_ff      <= csr_pwdata[15:0];
            gfpc_pkg::REG_INTERLACED:        interlaced_ff        <= csr_pwdata[0];
            gfpc_pkg::REG_TRANSPARENT_INDEX: transparent_index_ff <= csr_pwdata[7:0];
            gfpc_pkg::REG_TRANSPARENCY_MODE: transparency_mode_ff <= csr_pwdata[1:0];
            gfpc_pkg::REG_BACKGROUND_RGB:    background_rgb_ff    <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // Register readback is combinational off the address.
   always_comb begin
      unique case (csr_index)
         gfpc_pkg::REG_FRAME_LEFT:        csr_prdata = {16'd0, frame_left_ff};
         gfpc_pkg::REG_FRAME_TOP:         csr_prdata = {16'd0, frame_top_ff};
         gfpc_pkg::REG_FRAME_WIDTH:       csr_prdata = {16'd0, frame_width_ff};
         gfpc_pkg::REG_FRAME_HEIGHT:      csr_prdata = {16'd0, frame_height_ff};
         gfpc_pkg::REG_INTERLACED:        csr_prdata = {31'd0, interlaced_ff};
         gfpc_pkg::REG_TRANSPARENT_INDEX: csr_prdata = {24'd0, transparent_index_ff};
         gfpc_pkg::REG_TRANSPARENCY_MODE: csr_prdata = {30'd0, transparency_mode_ff};
         gfpc_pkg::REG_BACKGROUND_RGB:    csr_prdata = {8'd0, background_rgb_ff};
         default:                         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake. The design is a two-deep pipeline: stage one holds the
   // accepted transaction beside the palette RAM's registered read, and
   // the response register holds the finished result. Stage one moves on
   // whenever the response register is empty or being drained, so a new
   // request is taken in every cycle the downstream side keeps up.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_advance;
   logic accept, pixel_accept, palette_accept;

   logic [7:0]  in_slot;
   logic [23:0] in_rgb;
   logic [7:0]  in_index;
   logic        in_cmd;

   assign in_slot  = req_tdata[7:0];
   assign in_rgb   = req_tdata[31:8];
   assign in_index = req_tdata[39:32];
   assign in_cmd   = req_tuser;

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready     = !s1_valid_ff || s1_advance;
   assign accept         = req_tvalid && req_tready;
   assign pixel_accept   = accept && (in_cmd == gfpc_pkg::CMD_PIXEL);
   assign palette_accept = accept && (in_cmd == gfpc_pkg::CMD_PALETTE);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Palette RAM. Writes land at the accept edge; pixel lookups are
   // issued at the accept edge and the read data waits in the RAM's
   // output register until the next pixel is accepted, which also keeps
   // it steady while stage one is stalled.
   // ------------------------------------------------------------------
   logic        slot_in_range, index_in_range;
   logic [23:0] palette_rd_data;

   assign slot_in_range  = 32'(in_slot) < gfpc_pkg::PALETTE_ENTRIES;
   assign index_in_range = 32'(in_index) < gfpc_pkg::PALETTE_ENTRIES;

   gfpc_ram #(
      .WIDTH (gfpc_pkg::PIXEL_W),
      .DEPTH (gfpc_pkg::PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (palette_accept && slot_in_range),
      .wr_addr (in_slot[gfpc_pkg::PAL_ADDR_W-1:0]),
      .wr_data (in_rgb),
      .rd_en   (pixel_accept),
      .rd_addr (in_index[gfpc_pkg::PAL_ADDR_W-1:0]),
      .rd_data (palette_rd_data)
   );

   // ------------------------------------------------------------------
   // Position sequencing. The column counter advances on every pixel and the row counter
   // at each row end; a zero width or height counts as one, and a counter that wraps to
   // zero also ends its row or frame. In interlaced mode the next output
   // row steps through the four passes, skipping passes that have no row
   // inside the frame; if no pass has a row left the sequential row is used.
   // ------------------------------------------------------------------
   logic [15:0] column_count_ff, column_count_in;
   logic [15:0] row_count_ff, row_count_in;
   logic [1:0]  interlace_pass_ff, interlace_pass_in;
   logic [15:0] current_row_ff, current_row_in;

   logic [15:0] width_eff, height_eff;
   logic [15:0] column_plus, row_plus;
   logic        end_row, end_frame;
   logic [16:0] next_row;
   logic [1:0]  pass_work;

   assign width_eff   = (frame_width_ff == '0) ? 16'd1 : frame_width_ff;
   assign height_eff  = (frame_height_ff == '0) ? 16'd1 : frame_height_ff;
   assign column_plus = column_count_ff + 16'd1;
   assign row_plus    = row_count_ff + 16'd1;
   assign end_row     = (column_plus >= width_eff) || (column_plus == '0);
   assign end_frame   = (row_plus >= height_eff) || (row_plus == '0);

   // At most three pass changes can follow one step.
   always_comb begin
      next_row  = {1'b0, current_row_ff} + 17'(gfpc_pkg::pass_step(interlace_pass_ff));
      pass_work = interlace_pass_ff;
      for (int i = 0; i < 3; i++) begin
         if ((next_row >= {1'b0, height_eff}) && (pass_work != gfpc_pkg::LAST_PASS)) begin
            pass_work = pass_work + 2'd1;
            next_row  = 17'(gfpc_pkg::pass_start(pass_work));
         end
      end
   end

   always_comb begin
      column_count_in   = column_count_ff;
      row_count_in      = row_count_ff;
      interlace_pass_in = interlace_pass_ff;
      current_row_in    = current_row_ff;
      if (pixel_accept) begin
         if (!end_row) begin
            column_count_in = column_plus;
         end else if (end_frame) begin
            column_count_in   = '0;
            row_count_in      = '0;
            interlace_pass_in = '0;
            current_row_in    = '0;
         end else begin
            column_count_in = '0;
            row_count_in    = row_plus;
            if (interlaced_ff) begin
               interlace_pass_in = pass_work;
               current_row_in    = (next_row < {1'b0, height_eff}) ? next_row[15:0] : row_plus;
            end else begin
               current_row_in = row_plus;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff   <= '0;
         row_count_ff      <= '0;
         interlace_pass_ff <= '0;
         current_row_ff    <= '0;
      end else begin
         column_count_ff   <= column_count_in;
         row_count_ff      <= row_count_in;
         interlace_pass_ff <= interlace_pass_in;
         current_row_ff    <= current_row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage one: coordinates, frame end and the colour decision. A palette
   // write travels as a transaction with every response field zero.
   // ------------------------------------------------------------------
   logic        s1_pixel_ff, s1_skip_ff, s1_use_bg_ff, s1_in_range_ff, s1_done_ff;
   logic [15:0] s1_dest_x_ff, s1_dest_y_ff;
   logic        is_special;
   logic [15:0] dest_x_sum, dest_y_sum;

   assign is_special = (transparency_mode_ff != gfpc_pkg::MODE_NONE) &&
                       (in_index == transparent_index_ff);
   assign dest_x_sum = frame_left_ff + column_count_ff;
   assign dest_y_sum = frame_top_ff + current_row_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= pixel_accept;
         s1_skip_ff     <= is_special && (transparency_mode_ff != gfpc_pkg::MODE_BACKGROUND);
         s1_use_bg_ff   <= is_special && (transparency_mode_ff == gfpc_pkg::MODE_BACKGROUND);
         s1_in_range_ff <= index_in_range;
         s1_done_ff     <= pixel_accept && end_row && end_frame;
         s1_dest_x_ff   <= pixel_accept ? dest_x_sum : '0;
         s1_dest_y_ff   <= pixel_accept ? dest_y_sum : '0;
      end
   end

   // ------------------------------------------------------------------
   // Response register: colour select and packing.
   // ------------------------------------------------------------------
   logic [23:0] rgb_sel;
   logic        s1_write;
   logic [31:0] pixel_value;

   logic [63:0] rsp_tdata_ff;
   logic        rsp_tuser_ff, rsp_tlast_ff;

   assign rgb_sel     = s1_use_bg_ff   ? background_rgb_ff :
                        s1_in_range_ff ? palette_rd_data   : '0;
   assign s1_write    = s1_pixel_ff && !s1_skip_ff;
   assign pixel_value = s1_write ? gfpc_pkg::pack_pixel(rgb_sel) : '0;

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_tdata_ff <= {pixel_value, s1_dest_y_ff, s1_dest_x_ff};
         rsp_tuser_ff <= s1_write;
         rsp_tlast_ff <= s1_done_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire
